// ----- design/qsm_pkg.sv -----
// Shared constants, register codes and types for the quad stick mixer with PID.
// Used by qsm_axis and quad_stick_mixer_pid; depends on nothing else.

package qsm_pkg;

	// Field and datapath widths
	localparam int AXIS_W     = 10;   // stick axis, signed
	localparam int ANGLE_W    = 16;   // measured angle, signed Q8.8
	localparam int BYTE_W     = 8;    // deadzone, steps, throttle
	localparam int DUTY_W     = 8;
	localparam int GAIN_W     = 16;   // unsigned Q8.8 gains
	localparam int TARGET_W   = 9;    // plus or minus axis_step
	localparam int ERR_W      = 18;   // target * 256 - measured
	localparam int DIFF_W     = 19;   // error - last error
	localparam int SUM_W      = 32;   // saturated error sum
	localparam int KP_X_W     = 23;   // kp * 100
	localparam int KD_X_W     = 30;   // kd * 10000
	localparam int P_W        = KP_X_W + 1 + ERR_W;
	localparam int I_W        = GAIN_W + 1 + SUM_W;
	localparam int D_W        = KD_X_W + 1 + DIFF_W;
	localparam int LOOP_W     = 50;   // loop output, scaled by 100, Q16.16
	localparam int MIX_W      = 52;   // duty numerator before the divide
	localparam int THR100_W   = 15;   // throttle * 100

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PID_ENABLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KP_ROLL_PITCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_ROLL_PITCH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KP_YAW        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_KI_ALL        = 3'd7;

	// Scaling: the loop runs at dt = 0.01, so terms are kept multiplied by 100.
	localparam int DT_INV    = 100;
	localparam int DT_INV_SQ = DT_INV * DT_INV;
	localparam int Q16_SHIFT = 16;

	// Reset values of the registers
	localparam logic [BYTE_W-1:0] DEADZONE_RESET      = 8'd5;
	localparam logic [BYTE_W-1:0] THROTTLE_STEP_RESET = 8'd10;
	localparam logic [BYTE_W-1:0] AXIS_STEP_RESET     = 8'd10;
	localparam logic [GAIN_W-1:0] KI_ALL_RESET        = 16'd0;
	localparam logic [KP_X_W-1:0] KP_RP_X100_RESET    = KP_X_W'(307 * DT_INV);
	localparam logic [KD_X_W-1:0] KD_RP_X10000_RESET  = KD_X_W'(10 * DT_INV_SQ);
	localparam logic [KP_X_W-1:0] KP_YAW_X100_RESET   = KP_X_W'(512 * DT_INV);

	// Duty = numerator / (100 * 65536), truncated, clamped to 0..255.
	localparam logic signed [MIX_W-1:0] DUTY_SCALE = MIX_W'(DT_INV * 65536);
	localparam logic signed [MIX_W-1:0] DUTY_CEIL  = MIX_W'(255 * DT_INV * 65536);
	localparam logic [DUTY_W-1:0]       DUTY_MAX   = 8'hFF;

	// Below the ceiling the numerator shifted right by 16 is under 25500;
	// x / 100 is then exactly (x * 5243) >> 19.
	localparam int QX_W        = 15;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	typedef struct packed {
		logic load_s3;   // stage 3 takes an item
		logic update;    // the item also advances the loop memories
		logic load_s4;
		logic load_s5;
		logic pid_on;
	} pipe_ctl_t;

endpackage

// ----- design/qsm_axis.sv -----
// One PID loop: saturated error sum, derivative term, gain products, loop output.
// Depends on qsm_pkg; instantiated three times by quad_stick_mixer_pid.

module qsm_axis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qsm_pkg::pipe_ctl_t                   ctl,
	input  logic signed [qsm_pkg::TARGET_W-1:0]  target_s2,
	input  logic signed [qsm_pkg::ERR_W-1:0]     err_s2,
	input  logic        [qsm_pkg::KP_X_W-1:0]    kp_x100,
	input  logic        [qsm_pkg::KD_X_W-1:0]    kd_x10000,
	input  logic        [qsm_pkg::GAIN_W-1:0]    ki,
	output logic signed [qsm_pkg::LOOP_W-1:0]    loop_s5
);

	localparam logic signed [qsm_pkg::LOOP_W-1:0] DIRECT_SCALE =
		qsm_pkg::LOOP_W'(qsm_pkg::DUTY_SCALE);

	logic signed [qsm_pkg::SUM_W-1:0]    sum_q;
	logic signed [qsm_pkg::ERR_W-1:0]    last_q;
	logic signed [qsm_pkg::SUM_W:0]      sum_wide;
	logic signed [qsm_pkg::SUM_W-1:0]    sum_next;
	logic signed [qsm_pkg::DIFF_W-1:0]   diff;

	logic signed [qsm_pkg::TARGET_W-1:0] target_s3;
	logic signed [qsm_pkg::ERR_W-1:0]    err_s3;
	logic signed [qsm_pkg::SUM_W-1:0]    sum_s3;
	logic signed [qsm_pkg::DIFF_W-1:0]   diff_s3;

	logic signed [qsm_pkg::TARGET_W-1:0] target_s4;
	logic signed [qsm_pkg::P_W-1:0]      p_s4;
	logic signed [qsm_pkg::I_W-1:0]      i_s4;
	logic signed [qsm_pkg::D_W-1:0]      d_s4;

	logic signed [qsm_pkg::P_W-1:0]      p_d;
	logic signed [qsm_pkg::I_W-1:0]      i_d;
	logic signed [qsm_pkg::D_W-1:0]      d_d;
	logic signed [qsm_pkg::LOOP_W-1:0]   loop_d;

	// The error sum saturates rather than wrapping.
	always_comb begin
		sum_wide = (qsm_pkg::SUM_W+1)'(sum_q) + (qsm_pkg::SUM_W+1)'(err_s2);
		if (sum_wide[qsm_pkg::SUM_W] != sum_wide[qsm_pkg::SUM_W-1]) begin
			sum_next = sum_wide[qsm_pkg::SUM_W] ? {1'b1, {(qsm_pkg::SUM_W-1){1'b0}}}
			                                    : {1'b0, {(qsm_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_wide[qsm_pkg::SUM_W-1:0];
		end
		diff = qsm_pkg::DIFF_W'(err_s2) - qsm_pkg::DIFF_W'(last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (ctl.update) begin
			sum_q  <= sum_next;
			last_q <= err_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			target_s3 <= target_s2;
			err_s3    <= err_s2;
			sum_s3    <= sum_next;
			diff_s3   <= diff;
		end
	end

	always_comb begin
		p_d = $signed({1'b0, kp_x100}) * err_s3;
		i_d = $signed({1'b0, ki}) * sum_s3;
		d_d = $signed({1'b0, kd_x10000}) * diff_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			target_s4 <= target_s3;
			p_s4      <= p_d;
			i_s4      <= i_d;
			d_s4      <= d_d;
		end
	end

	// With the loop off the target is scaled like a loop output, so the
	// mixer and the divide treat both modes alike.
	always_comb begin
		if (ctl.pid_on) begin
			loop_d = qsm_pkg::LOOP_W'(p_s4) + qsm_pkg::LOOP_W'(i_s4)
			       + qsm_pkg::LOOP_W'(d_s4);
		end else begin
			loop_d = qsm_pkg::LOOP_W'(target_s4) * DIRECT_SCALE;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s5) begin
			loop_s5 <= loop_d;
		end
	end

	a_memory_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.update |=> $stable(sum_q) && $stable(last_q))
		else $error("loop memory changed without an update");

	a_last_error_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |=> last_q == $past(err_s2))
		else $error("last error does not follow the updated error");

	a_update_with_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |-> ctl.load_s3 && ctl.pid_on)
		else $error("loop memory updated outside an item transfer");

endmodule

// ----- design/quad_stick_mixer_pid.sv -----
// Top level of the quad stick mixer: sticks to targets, throttle, PID and X mixer.
// Depends on qsm_pkg and instantiates qsm_axis for roll, pitch and yaw.
//
// Usage: one input transfer carries a packet of four stick axes and the
// measured roll, pitch and yaw; for each one the block returns one transfer
// of four motor duties on the output channel, in order. Both channels use
// valid and ready. The configuration channel is always ready; a write lands
// on the edge of its transfer and must only be made while the block is empty.
// The duties of a packet pass through a seven stage pipeline (input register,
// targets and errors, throttle and loop memories, gain multipliers, loop sum,
// mixer, divide and clamp into the output register).
// Throughput: one packet per cycle while the receiver takes the results; the
// throttle and loop memories are updated by a single stage, so successive
// packets follow without gaps.
// Reset clears the pipeline, the throttle level and the loop memories and
// loads the default register values.
// When the receiver stalls, held results stay in place and empty stages ahead
// of them still fill; input ready falls only once all seven stages are full.

module quad_stick_mixer_pid (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_left_x,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_left_y,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_right_x,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_right_y,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_roll,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_pitch,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_yaw,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [qsm_pkg::DUTY_W-1:0]     duty_front_left,
	output logic        [qsm_pkg::DUTY_W-1:0]     duty_front_right,
	output logic        [qsm_pkg::DUTY_W-1:0]     duty_rear_left,
	output logic        [qsm_pkg::DUTY_W-1:0]     duty_rear_right,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [qsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [qsm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_STAGES = 7;

	// Direction of a stick after the deadzone: {deflected, negative}.
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b10;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	// Configuration
	logic [qsm_pkg::BYTE_W-1:0]   deadzone_q;
	logic [qsm_pkg::BYTE_W-1:0]   thr_step_q;
	logic [qsm_pkg::BYTE_W-1:0]   axis_step_q;
	logic                         pid_en_q;
	logic [qsm_pkg::KP_X_W-1:0]   kp_rp_x100_q;
	logic [qsm_pkg::KD_X_W-1:0]   kd_rp_x10000_q;
	logic [qsm_pkg::KP_X_W-1:0]   kp_yaw_x100_q;
	logic [qsm_pkg::GAIN_W-1:0]   ki_q;

	// Pipeline control
	logic [NUM_STAGES:1]          vld_q;
	logic [NUM_STAGES:1]          en;
	qsm_pkg::pipe_ctl_t           ctl;

	// Stage 1
	logic signed [qsm_pkg::AXIS_W-1:0]   lx_s1, ly_s1, rx_s1, ry_s1;
	logic signed [qsm_pkg::ANGLE_W-1:0]  mr_s1, mp_s1, my_s1;

	// Stage 2
	logic [1:0]                          ly_dir_s2;
	logic signed [qsm_pkg::TARGET_W-1:0] tr_s2, tp_s2, ty_s2;
	logic signed [qsm_pkg::ERR_W-1:0]    er_s2, ep_s2, ey_s2;
	logic signed [qsm_pkg::TARGET_W-1:0] tr_d, tp_d, ty_d;

	// Throttle
	logic [qsm_pkg::BYTE_W-1:0]          throttle_q;
	logic [qsm_pkg::BYTE_W:0]            thr_sum;
	logic [qsm_pkg::BYTE_W-1:0]          thr_next;
	logic [qsm_pkg::BYTE_W-1:0]          thr_s3, thr_s4;
	logic [qsm_pkg::THR100_W-1:0]        thr100_s5;

	// Loop outputs and mixer
	logic signed [qsm_pkg::LOOP_W-1:0]   lo_r_s5, lo_p_s5, lo_y_s5;
	logic signed [qsm_pkg::MIX_W-1:0]    base, r_ext, p_ext, y_ext;
	logic signed [qsm_pkg::MIX_W-1:0]    fl_s6, fr_s6, rl_s6, rr_s6;

	function automatic logic [1:0] axis_dir(
		input logic signed [qsm_pkg::AXIS_W-1:0] v,
		input logic        [qsm_pkg::BYTE_W-1:0] dz
	);
		logic [qsm_pkg::AXIS_W-1:0] mag;
		mag = v[qsm_pkg::AXIS_W-1] ? qsm_pkg::AXIS_W'(-v) : qsm_pkg::AXIS_W'(v);
		if (v == '0 || mag < qsm_pkg::AXIS_W'(dz)) begin
			return DIR_ZERO;
		end
		return v[qsm_pkg::AXIS_W-1] ? DIR_NEG : DIR_POS;
	endfunction

	function automatic logic signed [qsm_pkg::TARGET_W-1:0] dir_target(
		input logic [1:0]                 dir,
		input logic [qsm_pkg::BYTE_W-1:0] step
	);
		logic signed [qsm_pkg::TARGET_W-1:0] mag;
		mag = $signed({1'b0, step});
		case (dir)
			DIR_POS: return mag;
			DIR_NEG: return -mag;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [qsm_pkg::ERR_W-1:0] axis_error(
		input logic signed [qsm_pkg::TARGET_W-1:0] target,
		input logic signed [qsm_pkg::ANGLE_W-1:0]  measured
	);
		return (qsm_pkg::ERR_W'(target) <<< 8) - qsm_pkg::ERR_W'(measured);
	endfunction

	// Truncating divide by 100 * 65536 folded into the clamp: negative
	// numerators give zero and anything at or above the ceiling gives 255.
	function automatic logic [qsm_pkg::DUTY_W-1:0] to_duty(
		input logic signed [qsm_pkg::MIX_W-1:0] num
	);
		logic [qsm_pkg::QX_W-1:0]                 x;
		logic [qsm_pkg::QX_W+qsm_pkg::RECIP_W-1:0] prod;
		x    = num[qsm_pkg::Q16_SHIFT +: qsm_pkg::QX_W];
		prod = (qsm_pkg::QX_W+qsm_pkg::RECIP_W)'(x)
		     * (qsm_pkg::QX_W+qsm_pkg::RECIP_W)'(qsm_pkg::RECIP_100);
		if (num <= 0) begin
			return '0;
		end
		if (num >= qsm_pkg::DUTY_CEIL) begin
			return qsm_pkg::DUTY_MAX;
		end
		return prod[qsm_pkg::RECIP_SHIFT +: qsm_pkg::DUTY_W];
	endfunction

	// Configuration writes; the proportional and derivative gains are stored already
	// scaled by 100 and 10000 so that the multipliers see a single product per term.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q     <= qsm_pkg::DEADZONE_RESET;
			thr_step_q     <= qsm_pkg::THROTTLE_STEP_RESET;
			axis_step_q    <= qsm_pkg::AXIS_STEP_RESET;
			pid_en_q       <= 1'b0;
			kp_rp_x100_q   <= qsm_pkg::KP_RP_X100_RESET;
			kd_rp_x10000_q <= qsm_pkg::KD_RP_X10000_RESET;
			kp_yaw_x100_q  <= qsm_pkg::KP_YAW_X100_RESET;
			ki_q           <= qsm_pkg::KI_ALL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qsm_pkg::REG_DEADZONE:      deadzone_q  <= cfg_data[qsm_pkg::BYTE_W-1:0];
				qsm_pkg::REG_THROTTLE_STEP: thr_step_q  <= cfg_data[qsm_pkg::BYTE_W-1:0];
				qsm_pkg::REG_AXIS_STEP:     axis_step_q <= cfg_data[qsm_pkg::BYTE_W-1:0];
				qsm_pkg::REG_PID_ENABLE:    pid_en_q    <= cfg_data[0];
				qsm_pkg::REG_KP_ROLL_PITCH: begin
					kp_rp_x100_q <= qsm_pkg::KP_X_W'(cfg_data)
					              * qsm_pkg::KP_X_W'(qsm_pkg::DT_INV);
				end
				qsm_pkg::REG_KD_ROLL_PITCH: begin
					kd_rp_x10000_q <= qsm_pkg::KD_X_W'(cfg_data)
					                * qsm_pkg::KD_X_W'(qsm_pkg::DT_INV_SQ);
				end
				qsm_pkg::REG_KP_YAW: begin
					kp_yaw_x100_q <= qsm_pkg::KP_X_W'(cfg_data)
					               * qsm_pkg::KP_X_W'(qsm_pkg::DT_INV);
				end
				qsm_pkg::REG_KI_ALL:        ki_q <= cfg_data;
			endcase
		end
	end

	// A stage takes a new item when it is empty or its item moves on.
	always_comb begin
		en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (en[1] && in_valid) begin
			lx_s1 <= stick_left_x;
			ly_s1 <= stick_left_y;
			rx_s1 <= stick_right_x;
			ry_s1 <= stick_right_y;
			mr_s1 <= measured_roll;
			mp_s1 <= measured_pitch;
			my_s1 <= measured_yaw;
		end
	end

	// Stage 2: deadzone, targets and errors
	always_comb begin
		tr_d = dir_target(axis_dir(rx_s1, deadzone_q), axis_step_q);
		tp_d = dir_target(axis_dir(ry_s1, deadzone_q), axis_step_q);
		ty_d = dir_target(axis_dir(lx_s1, deadzone_q), axis_step_q);
	end

	always_ff @(posedge clk) begin
		if (en[2] && vld_q[1]) begin
			ly_dir_s2 <= axis_dir(ly_s1, deadzone_q);
			tr_s2     <= tr_d;
			tp_s2     <= tp_d;
			ty_s2     <= ty_d;
			er_s2     <= axis_error(tr_d, mr_s1);
			ep_s2     <= axis_error(tp_d, mp_s1);
			ey_s2     <= axis_error(ty_d, my_s1);
		end
	end

	// Stage 3: the throttle level saturates at both ends.
	always_comb begin
		thr_sum = {1'b0, throttle_q} + {1'b0, thr_step_q};
		case (ly_dir_s2)
			DIR_POS: thr_next = thr_sum[qsm_pkg::BYTE_W] ? qsm_pkg::DUTY_MAX
			                                             : thr_sum[qsm_pkg::BYTE_W-1:0];
			DIR_NEG: thr_next = (throttle_q < thr_step_q) ? '0 : throttle_q - thr_step_q;
			default: thr_next = throttle_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= '0;
		end else if (en[3] && vld_q[2]) begin
			throttle_q <= thr_next;
		end
	end

	always_comb begin
		ctl.load_s3 = en[3] && vld_q[2];
		ctl.update  = en[3] && vld_q[2] && pid_en_q;
		ctl.load_s4 = en[4] && vld_q[3];
		ctl.load_s5 = en[5] && vld_q[4];
		ctl.pid_on  = pid_en_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			thr_s3 <= thr_next;
		end
		if (ctl.load_s4) begin
			thr_s4 <= thr_s3;
		end
		if (ctl.load_s5) begin
			thr100_s5 <= qsm_pkg::THR100_W'(thr_s4) * qsm_pkg::THR100_W'(qsm_pkg::DT_INV);
		end
	end

	qsm_axis u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.target_s2 (tr_s2),
		.err_s2    (er_s2),
		.kp_x100   (kp_rp_x100_q),
		.kd_x10000 (kd_rp_x10000_q),
		.ki        (ki_q),
		.loop_s5   (lo_r_s5)
	);

	qsm_axis u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.target_s2 (tp_s2),
		.err_s2    (ep_s2),
		.kp_x100   (kp_rp_x100_q),
		.kd_x10000 (kd_rp_x10000_q),
		.ki        (ki_q),
		.loop_s5   (lo_p_s5)
	);

	// Yaw has no derivative term.
	qsm_axis u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.target_s2 (ty_s2),
		.err_s2    (ey_s2),
		.kp_x100   (kp_yaw_x100_q),
		.kd_x10000 ('0),
		.ki        (ki_q),
		.loop_s5   (lo_y_s5)
	);

	// Stage 6: X mixer on numerators scaled by 100 * 65536
	always_comb begin
		base  = $signed(qsm_pkg::MIX_W'({thr100_s5, {qsm_pkg::Q16_SHIFT{1'b0}}}));
		r_ext = qsm_pkg::MIX_W'(lo_r_s5);
		p_ext = qsm_pkg::MIX_W'(lo_p_s5);
		y_ext = qsm_pkg::MIX_W'(lo_y_s5);
	end

	always_ff @(posedge clk) begin
		if (en[6] && vld_q[5]) begin
			fl_s6 <= base + r_ext - p_ext + y_ext;
			fr_s6 <= base - r_ext - p_ext - y_ext;
			rl_s6 <= base + r_ext + p_ext - y_ext;
			rr_s6 <= base - r_ext + p_ext + y_ext;
		end
	end

	// Stage 7: divide, clamp and output register
	always_ff @(posedge clk) begin
		if (en[7] && vld_q[6]) begin
			duty_front_left  <= to_duty(fl_s6);
			duty_front_right <= to_duty(fr_s6);
			duty_rear_left   <= to_duty(rl_s6);
			duty_rear_right  <= to_duty(rr_s6);
		end
	end

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q) && !out_ready)
		else $error("input blocked while the pipeline has an empty stage");

	a_result_leaves_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without an output transfer");

	a_throttle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(en[3] && vld_q[2]) |=> $stable(throttle_q))
		else $error("throttle changed without an item passing stage 3");

endmodule

// ----- tb/qsm_duty_checker.sv -----
`timescale 1ns / 100ps
// Checker for quad_stick_mixer_pid: predicts the four motor duties of every packet
// and compares them with the output channel. Depends on qsm_pkg only.

module qsm_duty_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_left_x,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_left_y,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_right_x,
	input  logic signed [qsm_pkg::AXIS_W-1:0]     stick_right_y,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_roll,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_pitch,
	input  logic signed [qsm_pkg::ANGLE_W-1:0]    measured_yaw,

	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic        [qsm_pkg::DUTY_W-1:0]     duty_front_left,
	input  logic        [qsm_pkg::DUTY_W-1:0]     duty_front_right,
	input  logic        [qsm_pkg::DUTY_W-1:0]     duty_rear_left,
	input  logic        [qsm_pkg::DUTY_W-1:0]     duty_rear_right,

	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic        [qsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [qsm_pkg::CFG_DATA_W-1:0] cfg_data,

	output int                                    fail_count,
	output int                                    pending,
	output int                                    checked
);

	typedef struct packed {
		logic [qsm_pkg::DUTY_W-1:0] fl;
		logic [qsm_pkg::DUTY_W-1:0] fr;
		logic [qsm_pkg::DUTY_W-1:0] rl;
		logic [qsm_pkg::DUTY_W-1:0] rr;
	} duty_set_t;

	localparam longint ESUM_MAX = (longint'(1) <<< 31) - 1;
	localparam longint ESUM_MIN = -(longint'(1) <<< 31);
	localparam longint DUTY_DEN = longint'(qsm_pkg::DT_INV) <<< qsm_pkg::Q16_SHIFT;

	logic [qsm_pkg::BYTE_W-1:0] deadzone_q, throttle_step_q, axis_step_q;
	logic                       pid_on_q;
	logic [qsm_pkg::GAIN_W-1:0] kp_rp_q, kd_rp_q, kp_yaw_q, ki_q;

	logic [qsm_pkg::BYTE_W-1:0] throttle_q;
	longint                     err_sum [3];
	longint                     prev_err [3];

	duty_set_t expected_duties [$];
	duty_set_t want;
	int        errors = 0;
	int        n_checked = 0;

	function automatic longint stick_sign(input logic signed [qsm_pkg::AXIS_W-1:0] v);
		longint s;
		s = v;
		if (s == 0 || ((s < 0) ? -s : s) < longint'(deadzone_q))
			return 0;
		return (s > 0) ? 1 : -1;
	endfunction

	// Loop output kept exact, scaled by 100 in Q16.16; also advances the loop memories.
	function automatic longint loop_output(input int k, input longint target,
			input longint meas, input longint kp, input longint kd);
		longint err, sum, diff;
		err = target * 256 - meas;
		sum = err_sum[k] + err;
		if (sum > ESUM_MAX)
			sum = ESUM_MAX;
		else if (sum < ESUM_MIN)
			sum = ESUM_MIN;
		err_sum[k] = sum;
		diff = err - prev_err[k];
		prev_err[k] = err;
		return longint'(qsm_pkg::DT_INV) * kp * err + longint'(ki_q) * sum
			+ longint'(qsm_pkg::DT_INV_SQ) * kd * diff;
	endfunction

	function automatic logic [qsm_pkg::DUTY_W-1:0] clamp_duty(input longint v);
		if (v < 0)
			return '0;
		if (v > longint'(qsm_pkg::DUTY_MAX))
			return qsm_pkg::DUTY_MAX;
		return qsm_pkg::DUTY_W'(v);
	endfunction

	function automatic duty_set_t predict_duties(
			input logic signed [qsm_pkg::AXIS_W-1:0] lx,
			input logic signed [qsm_pkg::AXIS_W-1:0] ly,
			input logic signed [qsm_pkg::AXIS_W-1:0] rx,
			input logic signed [qsm_pkg::AXIS_W-1:0] ry,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_roll,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_pitch,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_yaw);
		longint    thr, yaw_t, pitch_t, roll_t, ro, po, yo, base;
		duty_set_t d;
		thr = longint'(throttle_q) + stick_sign(ly) * longint'(throttle_step_q);
		if (thr > longint'(qsm_pkg::DUTY_MAX))
			thr = longint'(qsm_pkg::DUTY_MAX);
		else if (thr < 0)
			thr = 0;
		throttle_q = qsm_pkg::BYTE_W'(thr);
		yaw_t = stick_sign(lx) * longint'(axis_step_q);
		pitch_t = stick_sign(ry) * longint'(axis_step_q);
		roll_t = stick_sign(rx) * longint'(axis_step_q);
		if (pid_on_q) begin
			ro = loop_output(0, roll_t, m_roll, kp_rp_q, kd_rp_q);
			po = loop_output(1, pitch_t, m_pitch, kp_rp_q, kd_rp_q);
			// The yaw loop has no derivative term.
			yo = loop_output(2, yaw_t, m_yaw, kp_yaw_q, 0);
			base = thr * DUTY_DEN;
			d.fl = clamp_duty((base + ro - po + yo) / DUTY_DEN);
			d.fr = clamp_duty((base - ro - po - yo) / DUTY_DEN);
			d.rl = clamp_duty((base + ro + po - yo) / DUTY_DEN);
			d.rr = clamp_duty((base - ro + po + yo) / DUTY_DEN);
		end else begin
			d.fl = clamp_duty(thr + roll_t - pitch_t + yaw_t);
			d.fr = clamp_duty(thr - roll_t - pitch_t - yaw_t);
			d.rl = clamp_duty(thr + roll_t + pitch_t - yaw_t);
			d.rr = clamp_duty(thr - roll_t + pitch_t + yaw_t);
		end
		return d;
	endfunction

	task automatic check_duty(input string field,
			input logic [qsm_pkg::DUTY_W-1:0] exp_v,
			input logic [qsm_pkg::DUTY_W-1:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
		end
	endtask

	// State is updated with blocking assignments as the prediction reads it back
	// straight away; only the counts handed to the top use nonblocking ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q = qsm_pkg::DEADZONE_RESET;
			throttle_step_q = qsm_pkg::THROTTLE_STEP_RESET;
			axis_step_q = qsm_pkg::AXIS_STEP_RESET;
			pid_on_q = 1'b0;
			kp_rp_q = 16'd307;
			kd_rp_q = 16'd10;
			kp_yaw_q = 16'd512;
			ki_q = qsm_pkg::KI_ALL_RESET;
			throttle_q = '0;
			for (int k = 0; k < 3; k++) begin
				err_sum[k] = 0;
				prev_err[k] = 0;
			end
			expected_duties.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_duties.size() == 0) begin
					errors++;
					$display("%0t: duty transfer with no packet outstanding, got %0d %0d %0d %0d",
						$time, duty_front_left, duty_front_right,
						duty_rear_left, duty_rear_right);
				end else begin
					want = expected_duties.pop_front();
					n_checked++;
					check_duty("duty_front_left", want.fl, duty_front_left);
					check_duty("duty_front_right", want.fr, duty_front_right);
					check_duty("duty_rear_left", want.rl, duty_rear_left);
					check_duty("duty_rear_right", want.rr, duty_rear_right);
				end
			end
			if (in_valid && in_ready)
				expected_duties.push_back(predict_duties(stick_left_x, stick_left_y,
					stick_right_x, stick_right_y, measured_roll, measured_pitch,
					measured_yaw));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qsm_pkg::REG_DEADZONE:
						deadzone_q = cfg_data[qsm_pkg::BYTE_W-1:0];
					qsm_pkg::REG_THROTTLE_STEP:
						throttle_step_q = cfg_data[qsm_pkg::BYTE_W-1:0];
					qsm_pkg::REG_AXIS_STEP:
						axis_step_q = cfg_data[qsm_pkg::BYTE_W-1:0];
					qsm_pkg::REG_PID_ENABLE:
						pid_on_q = cfg_data[0];
					qsm_pkg::REG_KP_ROLL_PITCH:
						kp_rp_q = cfg_data[qsm_pkg::GAIN_W-1:0];
					qsm_pkg::REG_KD_ROLL_PITCH:
						kd_rp_q = cfg_data[qsm_pkg::GAIN_W-1:0];
					qsm_pkg::REG_KP_YAW:
						kp_yaw_q = cfg_data[qsm_pkg::GAIN_W-1:0];
					qsm_pkg::REG_KI_ALL:
						ki_q = cfg_data[qsm_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
		end
		pending <= expected_duties.size();
		fail_count <= errors;
		checked <= n_checked;
	end

endmodule

// ----- tb/tb_quad_stick_mixer_pid.sv -----
`timescale 1ns / 100ps
// Top of the quad_stick_mixer_pid testbench: clock, reset, register settings and
// packet stimulus with random idling. Depends on qsm_pkg, quad_stick_mixer_pid and qsm_duty_checker.

module tb_quad_stick_mixer_pid;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;

	localparam logic signed [qsm_pkg::AXIS_W-1:0]  AXIS_MAX =
		{1'b0, {(qsm_pkg::AXIS_W-1){1'b1}}};
	localparam logic signed [qsm_pkg::AXIS_W-1:0]  AXIS_MIN =
		{1'b1, {(qsm_pkg::AXIS_W-1){1'b0}}};
	localparam logic signed [qsm_pkg::ANGLE_W-1:0] ANGLE_MAX =
		{1'b0, {(qsm_pkg::ANGLE_W-1){1'b1}}};
	localparam logic signed [qsm_pkg::ANGLE_W-1:0] ANGLE_MIN =
		{1'b1, {(qsm_pkg::ANGLE_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;

	logic                                  in_valid;
	logic                                  in_ready;
	logic signed [qsm_pkg::AXIS_W-1:0]     stick_left_x, stick_left_y;
	logic signed [qsm_pkg::AXIS_W-1:0]     stick_right_x, stick_right_y;
	logic signed [qsm_pkg::ANGLE_W-1:0]    measured_roll, measured_pitch, measured_yaw;

	logic                                  out_valid;
	logic                                  out_ready;
	logic        [qsm_pkg::DUTY_W-1:0]     duty_front_left, duty_front_right;
	logic        [qsm_pkg::DUTY_W-1:0]     duty_rear_left, duty_rear_right;

	logic                                  cfg_valid;
	logic                                  cfg_ready;
	logic        [qsm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic        [qsm_pkg::CFG_DATA_W-1:0] cfg_data;

	int fail_count, pending, checked;
	int quiet_cycles = 0;
	int n_sent = 0;
	int n_settings = 1;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	int cur_dz = int'(qsm_pkg::DEADZONE_RESET);

	quad_stick_mixer_pid u_top (.*);

	qsm_duty_checker u_checker (.*);

	always #2 clk = ~clk;

	function automatic logic [qsm_pkg::CFG_DATA_W-1:0] reg_mask(
			input logic [qsm_pkg::CFG_IDX_W-1:0] idx);
		case (idx) inside
			qsm_pkg::REG_DEADZONE, qsm_pkg::REG_THROTTLE_STEP, qsm_pkg::REG_AXIS_STEP:
				return 16'h00FF;
			qsm_pkg::REG_PID_ENABLE:
				return 16'h0001;
			default:
				return 16'hFFFF;
		endcase
	endfunction

	// Bits above a register's width carry junk, which the block must drop.
	task automatic write_reg(input logic [qsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [qsm_pkg::CFG_DATA_W-1:0] val);
		logic [qsm_pkg::CFG_DATA_W-1:0] m;
		m = reg_mask(idx);
		cfg_index <= idx;
		cfg_data <= (val & m) | (qsm_pkg::CFG_DATA_W'($urandom) & ~m);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input int dz, input int ts, input int as, input int pid,
			input int kp, input int kd, input int kpy, input int ki);
		write_reg(qsm_pkg::REG_DEADZONE, qsm_pkg::CFG_DATA_W'(dz));
		write_reg(qsm_pkg::REG_THROTTLE_STEP, qsm_pkg::CFG_DATA_W'(ts));
		write_reg(qsm_pkg::REG_AXIS_STEP, qsm_pkg::CFG_DATA_W'(as));
		write_reg(qsm_pkg::REG_PID_ENABLE, qsm_pkg::CFG_DATA_W'(pid));
		write_reg(qsm_pkg::REG_KP_ROLL_PITCH, qsm_pkg::CFG_DATA_W'(kp));
		write_reg(qsm_pkg::REG_KD_ROLL_PITCH, qsm_pkg::CFG_DATA_W'(kd));
		write_reg(qsm_pkg::REG_KP_YAW, qsm_pkg::CFG_DATA_W'(kpy));
		write_reg(qsm_pkg::REG_KI_ALL, qsm_pkg::CFG_DATA_W'(ki));
		cfg_valid <= 1'b0;
		cur_dz = dz & 'hFF;
		n_settings++;
	endtask

	task automatic send_packet(input logic signed [qsm_pkg::AXIS_W-1:0] lx,
			input logic signed [qsm_pkg::AXIS_W-1:0] ly,
			input logic signed [qsm_pkg::AXIS_W-1:0] rx,
			input logic signed [qsm_pkg::AXIS_W-1:0] ry,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_roll,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_pitch,
			input logic signed [qsm_pkg::ANGLE_W-1:0] m_yaw);
		int gap;
		gap = sender_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stick_left_x <= lx;
		stick_left_y <= ly;
		stick_right_x <= rx;
		stick_right_y <= ry;
		measured_roll <= m_roll;
		measured_pitch <= m_pitch;
		measured_yaw <= m_yaw;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Leans towards zero and the values either side of the deadzone edge.
	function automatic logic signed [qsm_pkg::AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return qsm_pkg::AXIS_W'(cur_dz);
			2:       return qsm_pkg::AXIS_W'(-cur_dz);
			3:       return qsm_pkg::AXIS_W'(cur_dz - 1);
			4:       return qsm_pkg::AXIS_W'(1 - cur_dz);
			5:       return $urandom_range(0, 1) ? AXIS_MAX : AXIS_MIN;
			default: return qsm_pkg::AXIS_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [qsm_pkg::ANGLE_W-1:0] rand_angle();
		case ($urandom_range(0, 5))
			0:       return ANGLE_MIN;
			1:       return ANGLE_MAX;
			2:       return qsm_pkg::ANGLE_W'(int'($urandom_range(0, 1023)) - 512);
			default: return qsm_pkg::ANGLE_W'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		repeat (n)
			send_packet(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
				rand_angle(), rand_angle(), rand_angle());
	endtask

	// Drives every loop error to one extreme so that the sums grow fast.
	task automatic push_integral(input int n, input bit downwards);
		repeat (n) begin
			if (downwards)
				send_packet(AXIS_MIN, rand_axis(), AXIS_MIN, AXIS_MIN,
					ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
			else
				send_packet(AXIS_MAX, rand_axis(), AXIS_MAX, AXIS_MAX,
					ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
		end
	endtask

	// Waits until every duty set of the phase has been transferred.
	task automatic finish_phase();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stick_left_x = '0;
		stick_left_y = '0;
		stick_right_x = '0;
		stick_right_y = '0;
		measured_roll = '0;
		measured_pitch = '0;
		measured_yaw = '0;
		cfg_valid = 1'b0;
		cfg_index = qsm_pkg::REG_DEADZONE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, direct mixing: deadzone edges and full deflection.
		send_packet(0, 0, 0, 0, 0, 0, 0);
		send_packet(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, ANGLE_MAX, ANGLE_MIN, 0);
		send_packet(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, ANGLE_MIN, ANGLE_MAX, -1);
		send_packet(4, 4, -4, 4, 0, 0, 0);
		send_packet(5, 5, -5, 5, 0, 0, 0);
		send_packet(-5, 5, 5, -5, 0, 0, 0);
		send_packet(-4, -5, 4, -4, 0, 0, 0);
		send_packet(-1, 1, AXIS_MIN, AXIS_MAX, 0, 0, 0);
		finish_phase();

		// No deadzone and full steps: throttle limits and duties out of range.
		program_regs(0, 255, 255, 0, 307, 10, 512, 0);
		send_packet(0, 0, 0, 0, 0, 0, 0);
		send_packet(1, 1, 1, 1, 0, 0, 0);
		send_packet(0, AXIS_MAX, 0, 0, 0, 0, 0);
		send_packet(-1, 0, 1, -1, 0, 0, 0);
		send_packet(0, -1, 0, 0, 0, 0, 0);
		send_packet(0, AXIS_MIN, 0, 0, 0, 0, 0);
		send_packet(AXIS_MAX, 0, AXIS_MIN, AXIS_MAX, 0, 0, 0);
		finish_phase();

		// PID on with measured angles at their extremes.
		program_regs(0, 255, 255, 1, 307, 10, 512, 300);
		send_packet(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
		send_packet(AXIS_MIN, 0, AXIS_MIN, AXIS_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
		send_packet(0, 0, 0, 0, 0, 0, 0);
		send_packet(0, -1, 0, 0, 256, -256, ANGLE_MAX);
		finish_phase();

		program_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			0, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		send_random(80);
		finish_phase();

		receiver_idle = 1'b0;
		program_regs(5, 10, 10, 1, 307, 10, 512, 40);
		send_random(80);
		finish_phase();

		sender_idle = 1'b0;
		receiver_idle = 1'b1;
		program_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			1, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		send_random(80);
		finish_phase();

		sender_idle = 1'b1;
		program_regs(255, 1, 1, 1, 0, 0, 0, 0);
		send_random(50);
		finish_phase();

		// Back to back, largest gains: every loop error held at one extreme, then the other.
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		program_regs(1, 255, 255, 1, 65535, 65535, 65535, 65535);
		push_integral(20, 1'b1);
		push_integral(40, 1'b0);
		finish_phase();

		// Small gains so that the grown sums show up in the duties.
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		program_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			1, $urandom_range(0, 600), $urandom_range(0, 60), $urandom_range(0, 600), 1);
		send_random(80);
		finish_phase();

		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		program_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			0, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		send_random(50);
		finish_phase();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Summary: %0d packets over %0d register settings, %0d duty sets compared.",
			n_sent, n_settings, checked);
		$display("Covered direct and PID mixing, deadzone edges, throttle limits and extreme errors.");
		if (fail_count == 0 && pending == 0)
			$display("tb_quad_stick_mixer_pid passed");
		else
			$display("tb_quad_stick_mixer_pid failed");
		$finish;
	end

	// Output side: while receiver_idle is set, a random stall before each duty transfer.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_idle ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("tb_quad_stick_mixer_pid failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
